>>> rtl/core/float_add_sub_mul_div_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the float add/sub/mul/div block
// Shared shorthands for clocked concurrent assertions with async reset.
// ----------------------------------------------------------------------------
`ifndef FLOAT_ADD_SUB_MUL_DIV_MACROS_SVH
`define FLOAT_ADD_SUB_MUL_DIV_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define FASMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fasmd assertion failed");

// consequent checked in the same cycle as the antecedent
`define FASMD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fasmd assertion failed");

`endif

>>> rtl/core/fasmd_pkg.sv
// ----------------------------------------------------------------------------
// fasmd_pkg
// Types, constants and helper functions of the float add/sub/mul/div block.
// ----------------------------------------------------------------------------
package fasmd_pkg;

  localparam int unsigned XW        = 63;
  localparam int unsigned SW        = 24;
  localparam int unsigned KW        = 12;
  localparam int unsigned CW        = 7;
  localparam int unsigned GUARD     = 38;
  localparam int unsigned MUL_STEPS = 24;
  localparam int unsigned DIV_SHIFT = 26;
  localparam int unsigned DIV_STEPS = 27;
  localparam int unsigned TOP       = 62;
  localparam int unsigned ALIGN_MAX = 62;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_e;
  typedef enum logic [1:0] {K_ZERO, K_FIN, K_INF, K_NAN} kind_e;
  typedef enum logic [1:0] {RM_RTZ, RM_RNE, RM_RUP, RM_RDN} rm_e;
  typedef enum logic {CFG_FORMAT_HALF, CFG_ROUNDING_MODE} cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NORM_OP, S_SETUP, S_ALIGN, S_ADD, S_NEG,
    S_MUL, S_DIV, S_NORM, S_DENORM, S_ROUND, S_SPEC
  } state_e;

  typedef struct packed {
    logic               sign;
    kind_e              kind;
    logic [SW-1:0]      sig;
    logic signed [KW-1:0] k;
  } opnd_t;

  typedef struct packed {
    logic special;
    logic ops_normed;
    logic one_zero;
    logic cnt_zero;
    logic cnt_last;
    logic diff_zero;
    logic neg;
    logic x_top;
    op_e  op;
  } dp_status_t;

  typedef struct packed {
    state_e state;
    logic   in_ready;
    logic   emit;
  } ctrl_t;

  function automatic opnd_t unpack(logic fmt, logic [31:0] bits);
    logic [7:0]  e;
    logic [22:0] m;
    logic        emax;
    opnd_t       r;
    if (fmt) begin
      e    = {3'b000, bits[14:10]};
      m    = {13'b0, bits[9:0]};
      emax = (bits[14:10] == 5'h1f);
      r.sign = bits[15];
    end else begin
      e    = bits[30:23];
      m    = bits[22:0];
      emax = (bits[30:23] == 8'hff);
      r.sign = bits[31];
    end
    r.sig = {1'b0, m};
    r.k   = '0;
    if (emax) begin
      r.kind = (m != '0) ? K_NAN : K_INF;
    end else if (e == 8'd0) begin
      r.kind = (m != '0) ? K_FIN : K_ZERO;
      r.k    = fmt ? -12'sd24 : -12'sd149;
    end else begin
      r.kind = K_FIN;
      r.sig  = fmt ? {13'b0, 1'b1, m[9:0]} : {1'b1, m};
      r.k    = $signed({4'b0000, e}) - (fmt ? 12'sd25 : 12'sd150);
    end
    return r;
  endfunction

  function automatic logic sig_top(logic fmt, logic [SW-1:0] sig);
    return fmt ? sig[10] : sig[23];
  endfunction

  function automatic logic [31:0] nan_bits(logic fmt);
    return fmt ? 32'h0000_7E00 : 32'h7FC0_0000;
  endfunction

  function automatic logic [31:0] inf_bits(logic fmt, logic s);
    return fmt ? {16'b0, s, 15'h7C00} : {s, 31'h7F80_0000};
  endfunction

  function automatic logic [31:0] zero_bits(logic fmt, logic s);
    return fmt ? {16'b0, s, 15'b0} : {s, 31'b0};
  endfunction

  function automatic kind_e class_of(logic fmt, logic [31:0] bits);
    logic       emax;
    logic       ezero;
    logic       mzero;
    kind_e      c;
    emax  = fmt ? (bits[14:10] == 5'h1f) : (bits[30:23] == 8'hff);
    ezero = fmt ? (bits[14:10] == 5'h00) : (bits[30:23] == 8'h00);
    mzero = fmt ? (bits[9:0] == 10'b0) : (bits[22:0] == 23'b0);
    if (emax)               c = mzero ? K_INF : K_NAN;
    else if (ezero && mzero) c = K_ZERO;
    else                    c = K_FIN;
    return c;
  endfunction

endpackage

>>> rtl/core/fasmd_if.sv
// ----------------------------------------------------------------------------
// fasmd_if
// Valid/ready channel interfaces for operands and results.
// ----------------------------------------------------------------------------
interface fasmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fasmd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic [1:0]  result_class;
  modport source (output valid, result_bits, result_class, input ready);
  modport sink (input valid, result_bits, result_class, output ready);
endinterface

>>> rtl/core/float_add_sub_mul_div.sv
// ----------------------------------------------------------------------------
// float_add_sub_mul_div
// IEEE 754 binary32/binary16 add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries opcode, operand_a and operand_b; a transaction completes
//         when valid and ready are both high. Binary16 uses the low 16 bits.
//   out_o carries result_bits and result_class, one transaction per input.
//   cfg_we_i/cfg_idx_i/cfg_data_i write format_half (index 0) and
//   rounding_mode (index 1); write them only while no operation is pending.
// Timing:
//   One operation at a time: in_i.ready is high only while the sequencer
//   idles. NaN, infinity and zero cases go from decode straight to output;
//   otherwise subnormal operands are normalized, then come 24 shift-add steps
//   for multiply or 27 restoring steps for divide, alignment and denormalizing
//   through the shared shifter, normalization and rounding.
//   Result is held in an output register; a stalled out_o holds it, and the
//   next result waits in the datapath until the register frees.
// Reset:
//   Asynchronous, active low; returns to idle, binary32, nearest-even.
// ----------------------------------------------------------------------------
module float_add_sub_mul_div import fasmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fasmd_in_if.sink    in_i,
  fasmd_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i
);

  logic        format_half_q;
  rm_e         rounding_mode_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_bits_q;
  kind_e       out_class_q;
  logic        in_fire;
  logic        out_free;
  dp_status_t  status;
  ctrl_t       ctrl;
  logic [31:0] dp_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_half_q   <= 1'b0;
      rounding_mode_q <= RM_RNE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FORMAT_HALF:   format_half_q   <= cfg_data_i[0];
        CFG_ROUNDING_MODE: rounding_mode_q <= rm_e'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  assign in_fire  = in_i.valid && ctrl.in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign out_valid_d = ctrl.emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_bits_q  <= dp_bits;
      out_class_q <= class_of(format_half_q, dp_bits);
    end
  end

  fasmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  fasmd_dp u_dp (
    .clk_i           (clk_i),
    .state_i         (ctrl.state),
    .in_fire_i       (in_fire),
    .opcode_i        (in_i.opcode),
    .operand_a_i     (in_i.operand_a),
    .operand_b_i     (in_i.operand_b),
    .format_half_i   (format_half_q),
    .rounding_mode_i (rounding_mode_q),
    .status_o        (status),
    .result_bits_o   (dp_bits)
  );

  assign in_i.ready         = ctrl.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.result_bits  = out_bits_q;
  assign out_o.result_class = out_class_q;

endmodule

>>> rtl/core/fasmd_ctrl.sv
// ----------------------------------------------------------------------------
// fasmd_ctrl
// Sequencer that steps the shared datapath through one operation.
// ----------------------------------------------------------------------------
module fasmd_ctrl import fasmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       out_free_i,
  input  dp_status_t status_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire_i) state_d = S_PREP;
      S_PREP:    state_d = status_i.special ? S_SPEC : S_NORM_OP;
      S_NORM_OP: if (status_i.ops_normed) state_d = S_SETUP;
      S_SETUP: begin
        case (status_i.op) inside
          OP_ADD, OP_SUB: state_d = status_i.one_zero ? S_NORM : S_ALIGN;
          OP_MUL:         state_d = S_MUL;
          default:        state_d = S_DIV;
        endcase
      end
      S_ALIGN:   if (status_i.cnt_zero) state_d = S_ADD;
      S_ADD: begin
        if (status_i.diff_zero)  state_d = S_SPEC;
        else if (status_i.neg)   state_d = S_NEG;
        else                     state_d = S_NORM;
      end
      S_NEG:     state_d = S_NORM;
      S_MUL:     if (status_i.cnt_last) state_d = S_NORM;
      S_DIV:     if (status_i.cnt_last) state_d = S_NORM;
      S_NORM:    if (status_i.x_top) state_d = S_DENORM;
      S_DENORM:  if (status_i.cnt_zero) state_d = S_ROUND;
      S_ROUND:   if (out_free_i) state_d = S_IDLE;
      S_SPEC:    if (out_free_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.state    = state_q;
    ctrl_o.in_ready = (state_q == S_IDLE);
    ctrl_o.emit     = ((state_q == S_ROUND) || (state_q == S_SPEC)) && out_free_i;
  end

endmodule

>>> rtl/core/fasmd_dp.sv
// ----------------------------------------------------------------------------
// fasmd_dp
// Operand registers, shared adder and jamming shifter, rounding and packing.
// ----------------------------------------------------------------------------
module fasmd_dp import fasmd_pkg::*; (
  input  logic        clk_i,
  input  state_e      state_i,
  input  logic        in_fire_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        format_half_i,
  input  rm_e         rounding_mode_i,
  output dp_status_t  status_o,
  output logic [31:0] result_bits_o
);

  op_e                  op_q;
  logic [31:0]          a_raw_q, b_raw_q;
  logic                 sa_q, sa_d, sb_q, sb_d;
  kind_e                kinda_q, kinda_d, kindb_q, kindb_d;
  logic [SW-1:0]        ma_q, ma_d, mb_q, mb_d;
  logic signed [KW-1:0] ka_q, ka_d, kb_q, kb_d;
  logic [XW-1:0]        x_q, x_d, y_q, y_d;
  logic signed [KW-1:0] k_q, k_d, be_q, be_d;
  logic                 sx_q, sx_d, sy_q, sy_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [31:0]          spec_q, spec_d;

  logic [XW-1:0]        alu_a, alu_b;
  logic                 alu_sub;
  logic [XW:0]          alu_sum;
  logic [XW-1:0]        sh_in, sh_out;
  logic                 sh_big;
  logic [CW-1:0]        sh_cnt;

  opnd_t                ua, ub;
  logic                 is_special;
  logic [31:0]          spec_val;
  logic                 na, nb;
  logic [31:0]          rnd_bits;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      op_q    <= op_e'(opcode_i);
      a_raw_q <= operand_a_i;
      b_raw_q <= operand_b_i;
    end
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    kinda_q <= kinda_d;
    kindb_q <= kindb_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    ka_q    <= ka_d;
    kb_q    <= kb_d;
    x_q     <= x_d;
    y_q     <= y_d;
    k_q     <= k_d;
    be_q    <= be_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    cnt_q   <= cnt_d;
    spec_q  <= spec_d;
  end

  // shared adder
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {XW{alu_sub}}} + (XW+1)'(alu_sub);

  // shared right shifter with sticky jam
  assign sh_in  = (state_i == S_ALIGN) ? y_q : x_q;
  assign sh_big = (cnt_q >= CW'(8));
  assign sh_out = sh_big ? ({8'b0, sh_in[XW-1:8]} | {{(XW-1){1'b0}}, |sh_in[7:0]})
                         : ({1'b0, sh_in[XW-1:1]} | {{(XW-1){1'b0}}, sh_in[0]});
  assign sh_cnt = cnt_q - (sh_big ? CW'(8) : CW'(1));

  // operand decode and special results
  always_comb begin
    logic s_md;
    ua = unpack(format_half_i, a_raw_q);
    ub = unpack(format_half_i, b_raw_q);
    if (op_q == OP_SUB) ub.sign = ~ub.sign;
    s_md       = ua.sign ^ ub.sign;
    is_special = 1'b1;
    spec_val   = nan_bits(format_half_i);
    if (ua.kind == K_NAN || ub.kind == K_NAN) begin
      spec_val = nan_bits(format_half_i);
    end else begin
      case (op_q) inside
        OP_ADD, OP_SUB: begin
          if (ua.kind == K_INF) begin
            spec_val = (ub.kind == K_INF && ua.sign != ub.sign) ? nan_bits(format_half_i)
                                                                : inf_bits(format_half_i, ua.sign);
          end else if (ub.kind == K_INF) begin
            spec_val = inf_bits(format_half_i, ub.sign);
          end else if (ua.kind == K_ZERO && ub.kind == K_ZERO) begin
            spec_val = zero_bits(format_half_i,
                                 (ua.sign == ub.sign) ? ua.sign : (rounding_mode_i == RM_RDN));
          end else begin
            is_special = 1'b0;
          end
        end
        OP_MUL: begin
          if ((ua.kind == K_ZERO && ub.kind == K_INF) || (ua.kind == K_INF && ub.kind == K_ZERO)) begin
            spec_val = nan_bits(format_half_i);
          end else if (ua.kind == K_INF || ub.kind == K_INF) begin
            spec_val = inf_bits(format_half_i, s_md);
          end else if (ua.kind == K_ZERO || ub.kind == K_ZERO) begin
            spec_val = zero_bits(format_half_i, s_md);
          end else begin
            is_special = 1'b0;
          end
        end
        default: begin
          if (ua.kind == ub.kind && (ua.kind == K_ZERO || ua.kind == K_INF)) begin
            spec_val = nan_bits(format_half_i);
          end else if (ua.kind == K_ZERO || ub.kind == K_INF) begin
            spec_val = zero_bits(format_half_i, s_md);
          end else if (ua.kind == K_INF || ub.kind == K_ZERO) begin
            spec_val = inf_bits(format_half_i, s_md);
          end else begin
            is_special = 1'b0;
          end
        end
      endcase
    end
  end

  assign na = (kinda_q != K_FIN) || sig_top(format_half_i, ma_q);
  assign nb = (kindb_q != K_FIN) || sig_top(format_half_i, mb_q);

  // rounding and packing
  always_comb begin
    logic [SW-1:0]   q;
    logic [SW:0]     q_r;
    logic            rbit, sticky, inc;
    logic [KW-1:0]   be_m1;
    logic [35:0]     enc, limit;
    logic            to_inf;
    if (format_half_i) begin
      q      = {13'b0, x_q[62:52]};
      rbit   = x_q[51];
      sticky = |x_q[50:0];
      limit  = 36'h0_0000_7C00;
    end else begin
      q      = x_q[62:39];
      rbit   = x_q[38];
      sticky = |x_q[37:0];
      limit  = 36'h0_7F80_0000;
    end
    case (rounding_mode_i)
      RM_RNE:  inc = rbit && (sticky || q[0]);
      RM_RUP:  inc = !sx_q && (rbit || sticky);
      RM_RDN:  inc = sx_q && (rbit || sticky);
      default: inc = 1'b0;
    endcase
    q_r   = {1'b0, q} + (SW+1)'(inc);
    be_m1 = be_q - 12'sd1;
    if (be_q >= 12'sd1) begin
      enc = (format_half_i ? {14'b0, be_m1, 10'b0} : {1'b0, be_m1, 23'b0}) + {11'b0, q_r};
    end else begin
      enc = {11'b0, q_r};
    end
    to_inf = (rounding_mode_i == RM_RNE) || (rounding_mode_i == RM_RUP && !sx_q) ||
             (rounding_mode_i == RM_RDN && sx_q);
    if (enc >= limit && !to_inf) enc = limit - 36'd1;
    rnd_bits = format_half_i ? {16'b0, sx_q, enc[14:0]} : {sx_q, enc[30:0]};
    if (enc >= limit) rnd_bits = inf_bits(format_half_i, sx_q);
  end

  // sequencing of the datapath registers
  always_comb begin
    logic                 swap;
    logic signed [KW-1:0] d;
    logic signed [KW-1:0] be_n;
    logic signed [KW-1:0] ext;
    logic                 ge;
    logic [XW-1:0]        rem_n;
    sa_d = sa_q;  sb_d = sb_q;  kinda_d = kinda_q;  kindb_d = kindb_q;
    ma_d = ma_q;  mb_d = mb_q;  ka_d = ka_q;  kb_d = kb_q;
    x_d = x_q;  y_d = y_q;  k_d = k_q;  be_d = be_q;
    sx_d = sx_q;  sy_d = sy_q;  cnt_d = cnt_q;  spec_d = spec_q;
    alu_a = x_q;  alu_b = y_q;  alu_sub = 1'b0;
    swap = (ka_q < kb_q);
    d = swap ? (kb_q - ka_q) : (ka_q - kb_q);
    be_n = k_q + KW'(TOP) + (format_half_i ? 12'sd15 : 12'sd127);
    ext = 12'sd1 - be_n;
    ge = 1'b0;
    rem_n = y_q;
    unique case (state_i)
      S_PREP: begin
        sa_d = ua.sign;  kinda_d = ua.kind;  ma_d = ua.sig;  ka_d = ua.k;
        sb_d = ub.sign;  kindb_d = ub.kind;  mb_d = ub.sig;  kb_d = ub.k;
        spec_d = spec_val;
      end
      S_NORM_OP: begin
        if (!na) begin
          ma_d = {ma_q[SW-2:0], 1'b0};
          ka_d = ka_q - 12'sd1;
        end
        if (!nb) begin
          mb_d = {mb_q[SW-2:0], 1'b0};
          kb_d = kb_q - 12'sd1;
        end
      end
      S_SETUP: begin
        case (op_q) inside
          OP_ADD, OP_SUB: begin
            if (kinda_q == K_ZERO) begin
              x_d = {39'b0, mb_q};  k_d = kb_q;  sx_d = sb_q;
            end else if (kindb_q == K_ZERO) begin
              x_d = {39'b0, ma_q};  k_d = ka_q;  sx_d = sa_q;
            end else begin
              x_d  = {1'b0, (swap ? mb_q : ma_q), 38'b0};
              y_d  = {1'b0, (swap ? ma_q : mb_q), 38'b0};
              sx_d = swap ? sb_q : sa_q;
              sy_d = swap ? sa_q : sb_q;
              k_d  = (swap ? kb_q : ka_q) - KW'(GUARD);
              if (d > KW'(ALIGN_MAX)) begin
                y_d   = {{(XW-1){1'b0}}, 1'b1};
                cnt_d = '0;
              end else begin
                cnt_d = d[CW-1:0];
              end
            end
          end
          OP_MUL: begin
            x_d = '0;  y_d = {39'b0, mb_q};  cnt_d = CW'(MUL_STEPS);
            k_d = ka_q + kb_q;  sx_d = sa_q ^ sb_q;
          end
          default: begin
            x_d = '0;  y_d = {39'b0, ma_q};  cnt_d = CW'(DIV_STEPS);
            k_d = ka_q - kb_q - KW'(DIV_SHIFT);  sx_d = sa_q ^ sb_q;
          end
        endcase
      end
      S_ALIGN: begin
        if (cnt_q != '0) begin
          y_d = sh_out;  cnt_d = sh_cnt;
        end
      end
      S_ADD: begin
        alu_sub = (sx_q != sy_q);
        x_d = alu_sum[XW-1:0];
        if (alu_sub && !alu_sum[XW]) sx_d = sy_q;
        spec_d = zero_bits(format_half_i, rounding_mode_i == RM_RDN);
      end
      S_NEG: begin
        alu_a = '0;  alu_b = x_q;  alu_sub = 1'b1;
        x_d = alu_sum[XW-1:0];
      end
      S_MUL: begin
        alu_a = {x_q[XW-2:0], 1'b0};
        alu_b = y_q[SW-1] ? {39'b0, ma_q} : '0;
        x_d   = alu_sum[XW-1:0];
        y_d   = {y_q[XW-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
      end
      S_DIV: begin
        alu_a = y_q;  alu_b = {39'b0, mb_q};  alu_sub = 1'b1;
        ge    = alu_sum[XW];
        rem_n = ge ? alu_sum[XW-1:0] : y_q;
        y_d   = {rem_n[XW-2:0], 1'b0};
        x_d   = {x_q[XW-2:0], ge} |
                {{(XW-1){1'b0}}, (cnt_q == CW'(1)) && (rem_n != '0)};
        cnt_d = cnt_q - CW'(1);
      end
      S_NORM: begin
        if (!x_q[XW-1]) begin
          if (x_q[XW-1:XW-8] == 8'b0) begin
            x_d = {x_q[XW-9:0], 8'b0};  k_d = k_q - 12'sd8;
          end else begin
            x_d = {x_q[XW-2:0], 1'b0};  k_d = k_q - 12'sd1;
          end
        end else begin
          be_d = be_n;
          if (be_n < 12'sd1) cnt_d = (ext > 12'sd63) ? CW'(63) : ext[CW-1:0];
          else               cnt_d = '0;
        end
      end
      S_DENORM: begin
        if (cnt_q != '0) begin
          x_d = sh_out;  cnt_d = sh_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.special    = is_special;
    status_o.ops_normed = na && nb;
    status_o.one_zero   = (kinda_q == K_ZERO) || (kindb_q == K_ZERO);
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.cnt_last   = (cnt_q == CW'(1));
    status_o.diff_zero  = (sx_q != sy_q) && (alu_sum[XW-1:0] == '0);
    status_o.neg        = (sx_q != sy_q) && !alu_sum[XW];
    status_o.x_top      = x_q[XW-1];
    status_o.op         = op_q;
  end

  assign result_bits_o = (state_i == S_SPEC) ? spec_q : rnd_bits;

endmodule

>>> rtl/core/fasmd_checker.sv
// ----------------------------------------------------------------------------
// fasmd_checker
// Port-level checks of the float add/sub/mul/div block, bound to the top.
// ----------------------------------------------------------------------------
`include "float_add_sub_mul_div_macros.svh"

module fasmd_checker import fasmd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_bits_i,
  input logic [1:0]  result_class_i
);

  `FASMD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `FASMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(result_bits_i) && $stable(result_class_i))
  `FASMD_ASSERT_NOW(a_nan_canonical, clk_i, rst_ni, out_valid_i && result_class_i == K_NAN, result_bits_i == 32'h7FC0_0000 || result_bits_i == 32'h0000_7E00)
  `FASMD_ASSERT_NOW(a_zero_class, clk_i, rst_ni, out_valid_i && result_class_i == K_ZERO, result_bits_i[30:0] == 31'b0 || (result_bits_i[31:16] == 16'b0 && result_bits_i[14:0] == 15'b0))

endmodule

bind float_add_sub_mul_div fasmd_checker u_fasmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_bits_i  (out_o.result_bits),
  .result_class_i (out_o.result_class)
);
